FILE: rtl/mbet_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the Mandelbrot escape-time pixel block.
// No dependencies; used by every module under rtl.
package mbet_pkg;

  localparam int COORD_W    = 32;  // signed Q4.28 coordinates and z parts
  localparam int FRAC_W     = 28;
  localparam int ITER_W     = 12;
  localparam int PX_W       = 10;
  localparam int PY_W       = 9;
  localparam int STEP_W     = 31;
  localparam int FACTOR_W   = 8;
  localparam int COLOR_W    = 8;
  localparam int SCREEN_W   = 640;
  localparam int SCREEN_H   = 480;
  localparam int RED_GAIN   = 15;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam int PROD_W = 2 * COORD_W;            // full product
  localparam int SQ_W   = PROD_W - FRAC_W;        // square, shifted by FRAC_W
  localparam int XP_W   = PROD_W - FRAC_W + 1;    // doubled cross product
  localparam int EXT_W  = STEP_W + PX_W + 3;      // headroom for map and update sums

  localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(4) << FRAC_W;

  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_STEP = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_FAC  = 3'd4;

  localparam logic [COORD_W-1:0]  ORIGIN_X_RST   = 32'hD555_5556;
  localparam logic [COORD_W-1:0]  ORIGIN_Y_RST   = 32'hE000_0000;
  localparam logic [STEP_W-1:0]   PIXEL_STEP_RST = 31'd2236962;
  localparam logic [ITER_W-1:0]   MAX_ITER_RST   = 12'd50;
  localparam logic [FACTOR_W-1:0] COLOR_FAC_RST  = 8'd10;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQR  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_HOLD = 4'b1000
  } mbet_state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic update;
    logic emit;
  } mbet_cmd_t;

  typedef struct packed {
    logic done;
  } mbet_stat_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [EXT_W-1:0] v);
    logic [EXT_W-COORD_W:0] hi_bits;
    hi_bits = v[EXT_W-1:COORD_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      return v[COORD_W-1:0];
    end else if (v[EXT_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: rtl/mandelbrot_escape_time_pixel_top.sv
`timescale 1ns / 1ps
// Top level of the Mandelbrot escape-time pixel block: controller plus datapath.
// Depends on mbet_pkg, mbet_ctrl, mbet_dp.
//
//  channel | ports                           | beat contents
//  --------+---------------------------------+------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata    | one pixel coordinate
//  out     | out_tvalid/out_tready/out_tdata | count and shades; in_set on out_tuser
//  cfg     | cfg_wen/cfg_addr/cfg_wdata      | one register write per asserted cycle
//
// A pixel runs its iterations between input beat and result beat:
// each iteration is a square phase (three 32x32 multipliers) and an update phase.
// One pixel is in flight at a time; the next beat is taken while the result waits.
// rst_n is synchronous; it restores register defaults and empties the output slot.
// A stalled result holds the datapath in place until out_tready returns.
module mandelbrot_escape_time_pixel_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mbet_pkg::IN_DATA_W-1:0]      in_tdata,   // pixel_x, pixel_y, zero pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mbet_pkg::OUT_DATA_W-1:0]     out_tdata,  // iterations, red, green, blue, pad
  output logic                                out_tuser,  // in_set
  input  logic                                cfg_wen,
  input  logic [mbet_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PAD_W = mbet_pkg::OUT_DATA_W - mbet_pkg::ITER_W - 3 * mbet_pkg::COLOR_W;

  mbet_pkg::mbet_cmd_t  cmd;
  mbet_pkg::mbet_stat_t stat;

  logic [mbet_pkg::ITER_W-1:0]  iterations;
  logic                         in_set;
  logic [mbet_pkg::COLOR_W-1:0] red, green, blue;

  mbet_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  mbet_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .pixel_x    (in_tdata[mbet_pkg::PX_W-1:0]),
    .pixel_y    (in_tdata[mbet_pkg::PX_W+mbet_pkg::PY_W-1:mbet_pkg::PX_W]),
    .cmd        (cmd),
    .stat       (stat),
    .iterations (iterations),
    .in_set     (in_set),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  assign out_tdata = {{PAD_W{1'b0}}, blue, green, red, iterations};
  assign out_tuser = in_set;

endmodule

FILE: rtl/mbet_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the escape-time pixel: handshakes, iteration phases, output slot.
// Depends on mbet_pkg.
module mbet_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output mbet_pkg::mbet_cmd_t  cmd,
  input  mbet_pkg::mbet_stat_t stat
);

  mbet_pkg::mbet_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == mbet_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      mbet_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = mbet_pkg::ST_SQR;
        end
      end
      mbet_pkg::ST_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = mbet_pkg::ST_UPD;
      end
      mbet_pkg::ST_UPD: begin
        if (!stat.done) begin
          cmd.update = 1'b1;
          state_nxt  = mbet_pkg::ST_SQR;
        end else if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mbet_pkg::ST_IDLE;
        end else begin
          state_nxt = mbet_pkg::ST_HOLD;
        end
      end
      mbet_pkg::ST_HOLD: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mbet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mbet_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbet_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/mbet_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, pixel mapping, z iteration, color shading, result register.
// Depends on mbet_pkg.
module mbet_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wen,
  input  logic [mbet_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [mbet_pkg::PX_W-1:0]           pixel_x,
  input  logic [mbet_pkg::PY_W-1:0]           pixel_y,
  input  mbet_pkg::mbet_cmd_t                 cmd,
  output mbet_pkg::mbet_stat_t                stat,
  output logic [mbet_pkg::ITER_W-1:0]         iterations,
  output logic                                in_set,
  output logic [mbet_pkg::COLOR_W-1:0]        red,
  output logic [mbet_pkg::COLOR_W-1:0]        green,
  output logic [mbet_pkg::COLOR_W-1:0]        blue
);

  localparam int CW = mbet_pkg::COORD_W;
  localparam int EW = mbet_pkg::EXT_W;
  localparam int SW = mbet_pkg::SQ_W;
  localparam int XW = mbet_pkg::XP_W;

  logic [CW-1:0]                     origin_x_r, origin_x_nxt;
  logic [CW-1:0]                     origin_y_r, origin_y_nxt;
  logic [mbet_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [mbet_pkg::ITER_W-1:0]       max_iter_r, max_iter_nxt;
  logic [mbet_pkg::FACTOR_W-1:0]     factor_r, factor_nxt;

  logic [mbet_pkg::PX_W-1:0]         px_c;
  logic [mbet_pkg::PY_W-1:0]         py_c;
  logic [mbet_pkg::STEP_W+mbet_pkg::PX_W-1:0] prod_x;
  logic [mbet_pkg::STEP_W+mbet_pkg::PY_W-1:0] prod_y;
  logic [EW-1:0]                     map_x, map_y;

  logic signed [CW-1:0]              cr_r, ci_r, zr_r, zi_r;
  logic signed [SW-1:0]              zr2_r, zi2_r;
  logic signed [XW-1:0]              xp_r;
  logic [mbet_pkg::ITER_W-1:0]       count_r;

  logic signed [mbet_pkg::PROD_W-1:0] p_rr, p_ii, p_ri;
  logic [SW:0]                       mag_sum;
  logic [EW-1:0]                     nzr_sum, nzi_sum;
  logic                              at_limit;

  logic [mbet_pkg::COLOR_W-1:0]      shade;
  logic [mbet_pkg::COLOR_W-1:0]      green_c, red_c;

  logic [mbet_pkg::ITER_W-1:0]       iter_out_r;
  logic                              in_set_r;
  logic [mbet_pkg::COLOR_W-1:0]      red_r, green_r;

  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    step_nxt     = step_r;
    max_iter_nxt = max_iter_r;
    factor_nxt   = factor_r;
    if (cfg_wen) begin
      case (cfg_addr)
        mbet_pkg::REG_ORIGIN_X:   origin_x_nxt = cfg_wdata[CW-1:0];
        mbet_pkg::REG_ORIGIN_Y:   origin_y_nxt = cfg_wdata[CW-1:0];
        mbet_pkg::REG_PIXEL_STEP: step_nxt     = cfg_wdata[mbet_pkg::STEP_W-1:0];
        mbet_pkg::REG_MAX_ITER:   max_iter_nxt = cfg_wdata[mbet_pkg::ITER_W-1:0];
        mbet_pkg::REG_COLOR_FAC:  factor_nxt   = cfg_wdata[mbet_pkg::FACTOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= mbet_pkg::ORIGIN_X_RST;
      origin_y_r <= mbet_pkg::ORIGIN_Y_RST;
      step_r     <= mbet_pkg::PIXEL_STEP_RST;
      max_iter_r <= mbet_pkg::MAX_ITER_RST;
      factor_r   <= mbet_pkg::COLOR_FAC_RST;
    end else begin
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      step_r     <= step_nxt;
      max_iter_r <= max_iter_nxt;
      factor_r   <= factor_nxt;
    end
  end

  // clamp off-screen pixels to the last column / row
  always_comb begin
    px_c = (pixel_x >= mbet_pkg::PX_W'(mbet_pkg::SCREEN_W)) ?
           mbet_pkg::PX_W'(mbet_pkg::SCREEN_W - 1) : pixel_x;
    py_c = (pixel_y >= mbet_pkg::PY_W'(mbet_pkg::SCREEN_H)) ?
           mbet_pkg::PY_W'(mbet_pkg::SCREEN_H - 1) : pixel_y;
    prod_x = step_r * px_c;
    prod_y = step_r * py_c;
    map_x  = {{(EW-CW){origin_x_r[CW-1]}}, origin_x_r} + EW'(prod_x);
    map_y  = {{(EW-CW){origin_y_r[CW-1]}}, origin_y_r} + EW'(prod_y);
  end

  always_comb begin
    p_rr = zr_r * zr_r;
    p_ii = zi_r * zi_r;
    p_ri = zr_r * zi_r;
  end

  always_comb begin
    mag_sum  = {1'b0, zr2_r} + {1'b0, zi2_r};
    at_limit = (count_r == max_iter_r);
    stat.done = (mag_sum > mbet_pkg::ESC_LIMIT) || at_limit;
    nzr_sum = {{(EW-SW){zr2_r[SW-1]}}, zr2_r} - {{(EW-SW){zi2_r[SW-1]}}, zi2_r}
            + {{(EW-CW){cr_r[CW-1]}}, cr_r};
    nzi_sum = {{(EW-XW){xp_r[XW-1]}}, xp_r} + {{(EW-CW){ci_r[CW-1]}}, ci_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r    <= mbet_pkg::sat_coord(map_x);
      ci_r    <= mbet_pkg::sat_coord(map_y);
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
    end else if (cmd.update) begin
      zr_r    <= mbet_pkg::sat_coord(nzr_sum);
      zi_r    <= mbet_pkg::sat_coord(nzi_sum);
      count_r <= count_r + mbet_pkg::ITER_W'(1);
    end
    if (cmd.square) begin
      zr2_r <= p_rr[mbet_pkg::PROD_W-1:mbet_pkg::FRAC_W];
      zi2_r <= p_ii[mbet_pkg::PROD_W-1:mbet_pkg::FRAC_W];
      xp_r  <= p_ri[mbet_pkg::PROD_W-1:mbet_pkg::FRAC_W-1];
    end
  end

  always_comb begin
    shade   = count_r[mbet_pkg::COLOR_W-1:0] * factor_r;
    green_c = shade[mbet_pkg::COLOR_W-1:0];
    red_c   = mbet_pkg::COLOR_W'(green_c * mbet_pkg::RED_GAIN);
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      iter_out_r <= count_r;
      in_set_r   <= at_limit;
      red_r      <= at_limit ? '0 : red_c;
      green_r    <= at_limit ? '0 : green_c;
    end
  end

  assign iterations = iter_out_r;
  assign in_set     = in_set_r;
  assign red        = red_r;
  assign green      = green_r;
  assign blue       = green_r;

endmodule

FILE: rtl/mbet_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the escape-time pixel top, attached with bind.
// Depends on mbet_pkg and mandelbrot_escape_time_pixel_top.
module mbet_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [mbet_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic                                out_tuser
);

  logic [mbet_pkg::COLOR_W-1:0] red, green, blue;

  assign red   = out_tdata[19:12];
  assign green = out_tdata[27:20];
  assign blue  = out_tdata[35:28];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the pixel was processed");

  a_black_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (red == '0) && (green == '0) && (blue == '0))
    else $error("in-set pixel is not black");

  a_shade_relation: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (blue == green) && (red == ({green[3:0], 4'b0000} - green)))
    else $error("shades out of step with each other");

endmodule

bind mandelbrot_escape_time_pixel_top mbet_chk u_mbet_chk (.*);
